// ===== hdl/arps_pkg.sv =====
package arps_pkg;

  // Defaults for the top-level parameters
  localparam int BANDS_DEFAULT        = 8;
  localparam int WIDTH_LIMIT_DEFAULT  = 320;
  localparam int ROOT_DEPTH_DEFAULT   = 1024;
  localparam int SQUARE_SHIFT_DEFAULT = 6;

  // Field and state widths
  localparam int BAND_W   = 3;
  localparam int LEVEL_W  = 8;
  localparam int GAP_W    = 8;
  localparam int HALF_W   = 7;
  localparam int INV_W    = 24;
  localparam int RADIUS_W = 10;
  // Root values for the default parameters fit in this width
  localparam int RAD_W    = 12;

  // Numerator of the inverse half gap
  localparam logic [INV_W-1:0] INV_NUM = 24'hFF0000;

  // Register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FLOOR_LEVEL  = 2'd2;

  // Geometry shared by all cells
  typedef struct packed {
    logic               setup;
    logic [GAP_W-1:0]   gap_new;
    logic [GAP_W-1:0]   gap;
    logic [HALF_W-1:0]  half;
    logic [INV_W-1:0]   inv;
    logic [LEVEL_W-1:0] floor_level;
  } arps_cfg_t;

  // One item on its way down the chain
  typedef struct packed {
    logic               valid;
    logic               pix;
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
    logic [RAD_W-1:0]   rad;
    logic               hit;
    logic [LEVEL_W-1:0] falloff;
    logic [LEVEL_W-1:0] best;
  } arps_item_t;

endpackage

// ===== hdl/arps_root_table.sv =====
module arps_root_table import arps_pkg::*; #(
  parameter int ROOT_DEPTH   = ROOT_DEPTH_DEFAULT,
  parameter int SQUARE_SHIFT = SQUARE_SHIFT_DEFAULT,
  parameter int RW           = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [$clog2(ROOT_DEPTH)-1:0] addr,
  output logic [RW-1:0]                 rd_data,
  output logic                          busy
);

  localparam int AW = $clog2(ROOT_DEPTH);
  localparam int NW = AW + SQUARE_SHIFT;
  localparam int TW = 2 * RW + 1;

  logic [RW-1:0] mem [ROOT_DEPTH];
  logic [AW-1:0] fill_idx;
  logic [RW-1:0] root;
  logic [TW-1:0] thresh;
  logic [TW-1:0] n_ext;
  logic          step_up;

  // Scaled index and the rounding threshold root*root + root
  assign n_ext   = TW'(NW'(fill_idx) << SQUARE_SHIFT);
  assign step_up = n_ext > thresh;

  // Sweep the table once after reset, raising the root as the index grows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      fill_idx <= '0;
      root     <= '0;
      thresh   <= '0;
    end else if (busy) begin
      if (step_up) begin
        root   <= root + RW'(1);
        thresh <= thresh + TW'({root, 1'b0}) + TW'(2);
      end else if (fill_idx == AW'(ROOT_DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        fill_idx <= fill_idx + AW'(1);
      end
    end
  end

  // Write during the sweep, registered read afterwards
  always_ff @(posedge clk) begin
    if (busy && !step_up) begin
      mem[fill_idx] <= root;
    end
    if (en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== hdl/arps_cell.sv =====
module arps_cell import arps_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  arps_cfg_t  cfg,
  input  arps_item_t in_item,
  output arps_item_t out_item
);

  localparam logic [RADIUS_W-1:0] MULT = RADIUS_W'(IDX + 1);

  logic [LEVEL_W-1:0]      level;
  logic [LEVEL_W-1:0]      lit;
  logic [RADIUS_W-1:0]     radius;
  arps_item_t              mid;
  arps_item_t              mid_next;
  arps_item_t              out_next;
  logic [RADIUS_W-1:0]     base_new;
  logic [RADIUS_W-1:0]     base_cur;
  logic [2*LEVEL_W-1:0]    lvl_gap;
  logic [RADIUS_W-1:0]     radius_upd;
  logic signed [RAD_W+1:0] diff;
  logic [RAD_W:0]          rad_dist;
  logic [HALF_W+INV_W-1:0] fall_prod;
  logic [2*LEVEL_W-1:0]    lit_prod;
  logic [LEVEL_W-1:0]      lit_next;
  logic [2*LEVEL_W-1:0]    v_prod;
  logic [LEVEL_W-1:0]      v;
  logic                    band_hit;

  // Ring radius of this band at rest and after a level update
  assign base_new   = {{(RADIUS_W-GAP_W){1'b0}}, cfg.gap_new} * MULT;
  assign base_cur   = {{(RADIUS_W-GAP_W){1'b0}}, cfg.gap} * MULT;
  assign lvl_gap    = {{GAP_W{1'b0}}, in_item.level} * {{LEVEL_W{1'b0}}, cfg.gap};
  assign radius_upd = base_cur + RADIUS_W'(lvl_gap >> 10);
  assign band_hit   = in_item.valid && !in_item.pix && (32'(in_item.band) == 32'(IDX));

  // Distance of the pixel radius to this ring, linear falloff inside half a gap
  assign diff = signed'({2'b00, in_item.rad}) -
                signed'({{(RAD_W+2-RADIUS_W){1'b0}}, radius});
  assign rad_dist  = diff[RAD_W+1] ? (RAD_W+1)'(-diff) : diff[RAD_W:0];
  assign fall_prod = {{INV_W{1'b0}}, rad_dist[HALF_W-1:0]} * {{HALF_W{1'b0}}, cfg.inv};

  always_comb begin
    mid_next         = in_item;
    mid_next.hit     = in_item.pix && (rad_dist < {{(RAD_W+1-HALF_W){1'b0}}, cfg.half});
    mid_next.falloff = 8'd255 - LEVEL_W'(fall_prod >> 16);
  end

  // Floored level brightness
  assign lit_prod = {{LEVEL_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, 8'd255 - cfg.floor_level};
  assign lit_next = cfg.floor_level + lit_prod[2*LEVEL_W-1:LEVEL_W];

  // Keep the brighter of this ring and the best so far
  assign v_prod = {{LEVEL_W{1'b0}}, mid.falloff} * {{LEVEL_W{1'b0}}, lit};
  assign v      = v_prod[2*LEVEL_W-1:LEVEL_W];

  always_comb begin
    out_next = mid;
    if (mid.hit && (v > mid.best)) begin
      out_next.best = v;
    end
  end

  // Band state
  always_ff @(posedge clk) begin
    lit <= lit_next;
    if (cfg.setup) begin
      level  <= '0;
      radius <= base_new;
    end else if (en && band_hit) begin
      level  <= in_item.level;
      radius <= radius_upd;
    end
  end

  // Advance the two stages of the cell
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid      <= 1'b0;
      out_item.valid <= 1'b0;
    end else if (en) begin
      mid      <= mid_next;
      out_item <= out_next;
    end
  end

endmodule

// ===== hdl/audio_ring_pixel_shader_top.sv =====
// Audio ring pixel shader.
// Input channel s_*: one item per handshake. s_tuser is the action (0 = band
// level update, 1 = shade one pixel). Band items produce no result; pixel
// items produce exactly one result on m_*: m_tdata holds the shade and
// m_tuser flags a background pixel.
// Items flow down a chain of BANDS cells, one per band, each holding that
// band's level and ring radius. Band items travel the same chain, so updates
// and pixels stay in order.
// Throughput: one item per cycle while the pipeline does not hold. Each item
// passes three front stages (offsets, table index, root table read), two
// stages per cell and the output register.
// When a result waits with m_tready low the whole pipeline holds and
// s_tready drops.
// Reset: the root table is filled by a sweep over all ROOT_DEPTH entries;
// setup and the bit-serial divide of the inverse half gap run during that
// sweep, and s_tready stays low meanwhile. A valid frame size write reruns
// setup and holds input until the divide ends; any other write holds input
// for one cycle.
module audio_ring_pixel_shader_top import arps_pkg::*; #(
  parameter int BANDS        = BANDS_DEFAULT,
  parameter int WIDTH_LIMIT  = WIDTH_LIMIT_DEFAULT,
  parameter int ROOT_DEPTH   = ROOT_DEPTH_DEFAULT,
  parameter int SQUARE_SHIFT = SQUARE_SHIFT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // band[2:0], band_level[18:3], pixel_x[27:19], pixel_y[37:28], zero fill
  input  logic [39:0] s_tdata,
  // action
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // shade[7:0]
  output logic [7:0]  m_tdata,
  // background
  output logic        m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(ROOT_DEPTH);
  localparam int NW    = AW + SQUARE_SHIFT;
  localparam int RW    = (NW + 1) / 2 + 1;
  localparam int D_W   = 11;
  localparam int CNT_W = $clog2(INV_W);

  // Configuration registers and derived geometry
  logic [8:0]         frame_width;
  logic [9:0]         frame_height;
  logic [LEVEL_W-1:0] floor_level;
  logic [7:0]         centre_x;
  logic [8:0]         centre_y;
  logic [GAP_W-1:0]   gap_pixels;
  logic [HALF_W-1:0]  half_gap;
  logic [INV_W-1:0]   inverse_half;
  logic               setup_go;
  logic               cfg_hold;
  logic               wr_en;
  logic [8:0]         maxr;
  logic [GAP_W-1:0]   gap_new;
  logic [HALF_W-1:0]  half_new;

  // Divider
  logic               div_busy;
  logic [CNT_W-1:0]   div_cnt;
  logic [HALF_W-1:0]  div_rem;
  logic [HALF_W-1:0]  div_den;
  logic [INV_W-1:0]   div_num;
  logic [HALF_W:0]    rem_sh;
  logic               rem_ge;

  // Pipeline
  logic               busy;
  logic               en;
  logic               accept;
  logic               fill_busy;
  arps_item_t         p0;
  arps_item_t         p1;
  arps_item_t         p2;
  arps_item_t         chain_in;
  arps_item_t         chain [BANDS+1];
  arps_cfg_t          cfg;
  logic signed [D_W-1:0]   p0_dx;
  logic signed [D_W-1:0]   p0_dy;
  logic signed [2*D_W-1:0] sq_x;
  logic signed [2*D_W-1:0] sq_y;
  logic [2*D_W-1:0]        sq_sum;
  logic [2*D_W-1:0]        idx_full;
  logic [AW-1:0]           p1_idx;
  logic [RW-1:0]           root_rd;
  logic [LEVEL_W-1:0]      lvl_clamp;
  logic [15:0]             in_level;
  logic [2*LEVEL_W-1:0]    shade_prod;

  // APB port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = {23'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {22'd0, frame_height};
      REG_FLOOR_LEVEL:  prdata = {24'd0, floor_level};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd320;
      frame_height <= 10'd240;
      floor_level  <= 8'd64;
      setup_go     <= 1'b1;
      cfg_hold     <= 1'b0;
    end else begin
      setup_go <= 1'b0;
      cfg_hold <= wr_en;
      if (wr_en) begin
        unique case (paddr[3:2])
          REG_FRAME_WIDTH: begin
            if ((pwdata[8:0] != 9'd0) && ({2'b00, pwdata[8:0]} <= 11'(WIDTH_LIMIT))) begin
              frame_width <= pwdata[8:0];
              setup_go    <= 1'b1;
            end
          end
          REG_FRAME_HEIGHT: begin
            if (pwdata[9:0] != 10'd0) begin
              frame_height <= pwdata[9:0];
              setup_go     <= 1'b1;
            end
          end
          REG_FLOOR_LEVEL: floor_level <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Geometry from the frame size
  assign maxr     = ({1'b0, frame_width[8:1]} < frame_height[9:1]) ?
                    {1'b0, frame_width[8:1]} : frame_height[9:1];
  assign gap_new  = GAP_W'(maxr / BANDS);
  assign half_new = gap_new[GAP_W-1:1];

  always_ff @(posedge clk) begin
    if (setup_go) begin
      centre_x   <= frame_width[8:1];
      centre_y   <= frame_height[9:1];
      gap_pixels <= gap_new;
      half_gap   <= half_new;
    end
  end

  // Bit-serial divide of the inverse numerator by the half gap
  assign rem_sh = {div_rem, div_num[INV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (setup_go) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + CNT_W'(1);
      if (div_cnt == CNT_W'(INV_W - 1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (setup_go) begin
      div_rem      <= '0;
      div_num      <= INV_NUM;
      div_den      <= (half_new == '0) ? HALF_W'(1) : half_new;
      inverse_half <= '0;
    end else if (div_busy) begin
      div_num      <= {div_num[INV_W-2:0], 1'b0};
      div_rem      <= rem_ge ? HALF_W'(rem_sh - {1'b0, div_den}) : rem_sh[HALF_W-1:0];
      inverse_half <= {inverse_half[INV_W-2:0], rem_ge};
    end
  end

  // Handshake: the whole pipeline advances when the output slot frees up
  assign busy     = fill_busy || div_busy || setup_go || cfg_hold;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !busy;
  assign accept   = s_tvalid && s_tready;

  // Clamp the level of a band item
  assign in_level  = s_tdata[18:3];
  assign lvl_clamp = in_level[15] ? 8'd0 : ((|in_level[14:8]) ? 8'd255 : in_level[7:0]);

  // Front stage: offsets to the centre
  always_ff @(posedge clk) begin
    if (rst) begin
      p0.valid <= 1'b0;
    end else if (en) begin
      p0.valid   <= accept;
      p0.pix     <= s_tuser;
      p0.band    <= s_tdata[2:0];
      p0.level   <= lvl_clamp;
      p0.rad     <= '0;
      p0.hit     <= 1'b0;
      p0.falloff <= '0;
      p0.best    <= '0;
      p0_dx      <= signed'({2'b00, s_tdata[27:19]}) - signed'({3'b000, centre_x});
      p0_dy      <= signed'({1'b0, s_tdata[37:28]}) - signed'({2'b00, centre_y});
    end
  end

  // Squared distance, scaled and saturated into a table index
  assign sq_x     = p0_dx * p0_dx;
  assign sq_y     = p0_dy * p0_dy;
  assign sq_sum   = unsigned'(sq_x) + unsigned'(sq_y);
  assign idx_full = sq_sum >> SQUARE_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
    end else if (en) begin
      p1     <= p0;
      p1_idx <= (idx_full > (2*D_W)'(ROOT_DEPTH - 1)) ? AW'(ROOT_DEPTH - 1) : AW'(idx_full);
    end
  end

  arps_root_table #(
    .ROOT_DEPTH   (ROOT_DEPTH),
    .SQUARE_SHIFT (SQUARE_SHIFT),
    .RW           (RW)
  ) u_root (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .addr    (p1_idx),
    .rd_data (root_rd),
    .busy    (fill_busy)
  );

  // Carry the item alongside the table read
  always_ff @(posedge clk) begin
    if (rst) begin
      p2.valid <= 1'b0;
    end else if (en) begin
      p2 <= p1;
    end
  end

  always_comb begin
    chain_in     = p2;
    chain_in.rad = RAD_W'(root_rd);
  end

  assign cfg.setup       = setup_go;
  assign cfg.gap_new     = gap_new;
  assign cfg.gap         = gap_pixels;
  assign cfg.half        = half_gap;
  assign cfg.inv         = inverse_half;
  assign cfg.floor_level = floor_level;

  // Row of band cells
  assign chain[0] = chain_in;

  for (genvar g = 0; g < BANDS; g++) begin : g_cell
    arps_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cfg      (cfg),
      .in_item  (chain[g]),
      .out_item (chain[g+1])
    );
  end

  // Output register: square the best brightness, drop band items
  assign shade_prod = {{LEVEL_W{1'b0}}, chain[BANDS].best} *
                      {{LEVEL_W{1'b0}}, chain[BANDS].best};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain[BANDS].valid && chain[BANDS].pix;
      m_tdata  <= shade_prod[2*LEVEL_W-1:LEVEL_W];
      m_tuser  <= (chain[BANDS].best == '0);
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input accepted while table fill or setup runs");

  a_setup_divides : assert property (@(posedge clk) disable iff (rst)
    setup_go |=> div_busy)
    else $error("setup did not start the divider");

  a_background_dark : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
    else $error("background pixel with nonzero shade");

  a_shade_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= 8'd252))
    else $error("shade out of range");
`endif

endmodule
